FILE: rtl/core/rau_pkg.sv
// Package for the rational arithmetic unit: operation codes, widths, shared types.
// No dependencies.
package rau_pkg;

	localparam int unsigned OperandWidth = 32;
	localparam int unsigned FieldWidth = 32;
	localparam int unsigned ResWidth = 64;
	localparam int unsigned QueueDepth = 2;

	typedef enum logic [2:0] {
		FUNC_ADD = 3'd0,
		FUNC_SUB = 3'd1,
		FUNC_MUL = 3'd2,
		FUNC_DIV = 3'd3,
		FUNC_CMP = 3'd4
	} func_t;

	// classified item handed from front to back
	typedef struct packed {
		logic               err;
		logic               cmp;
		logic signed [63:0] num;
		logic [63:0]        den;
		logic               lt;
		logic               eq;
		logic               gt;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_OUT
	} bk_state_t;

endpackage

FILE: rtl/core/rau_if.sv
// Valid/ready channel carrying one item of payload type T.
// Depends on nothing.
interface rau_if #(parameter type T = logic) (input logic clk);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/rau_front.sv
// Front part: reads operands, forms cross products over two stages, classifies.
// Depends on rau_pkg.
module rau_front #(
	parameter int unsigned OPERAND_WIDTH = rau_pkg::OperandWidth
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [2:0]                   in_func,
	input  logic signed [31:0]           in_an,
	input  logic signed [31:0]           in_ad,
	input  logic signed [31:0]           in_bn,
	input  logic signed [31:0]           in_bd,
	output logic                         job_valid,
	input  logic                         job_ready,
	output rau_pkg::job_t                job
);
	import rau_pkg::*;

	localparam logic [OPERAND_WIDTH-1:0] MinV = {1'b1, {(OPERAND_WIDTH-1){1'b0}}};

	function automatic logic signed [32:0] rd(input logic [31:0] raw);
		logic [OPERAND_WIDTH-1:0] u;
		logic signed [32:0] v;
		begin
			u = raw[OPERAND_WIDTH-1:0];
			if (u == MinV)
				u = MinV + 1'b1;
			v = 33'(signed'(u));
			rd = v;
		end
	endfunction

	// stage 1: saturated, sign-normalized operands
	logic               v_s1;
	logic [2:0]         func_s1;
	logic               err_s1;
	logic signed [32:0] an_s1, ad_s1, bn_s1, bd_s1;
	// stage 2: products
	logic               v_s2;
	logic [2:0]         func_s2;
	logic               err_s2;
	logic signed [63:0] p1_s2, p2_s2, p3_s2, p4_s2;

	logic adv2, adv1;
	assign adv2 = !v_s2 || job_ready;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	logic signed [32:0] an, ad, bn, bd;
	logic bad;
	always_comb begin
		an = rd(in_an);
		ad = rd(in_ad);
		bn = rd(in_bn);
		bd = rd(in_bd);
		bad = (ad == 0) || (bd == 0) || (in_func > 3'(FUNC_CMP)) ||
			(in_func == 3'(FUNC_DIV) && bn == 0);
		if (ad < 0) begin
			ad = -ad;
			an = -an;
		end
		if (bd < 0) begin
			bd = -bd;
			bn = -bn;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1)
				v_s1 <= in_valid;
			if (adv2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			func_s1 <= in_func;
			err_s1 <= bad;
			an_s1 <= an;
			ad_s1 <= ad;
			bn_s1 <= bn;
			bd_s1 <= bd;
		end
		if (adv2 && v_s1) begin
			func_s2 <= func_s1;
			err_s2 <= err_s1;
			p1_s2 <= 64'(an_s1 * bd_s1);
			p2_s2 <= (func_s1 == 3'(FUNC_MUL)) ? 64'(an_s1 * bn_s1) : 64'(bn_s1 * ad_s1);
			p3_s2 <= 64'(ad_s1 * bd_s1);
			p4_s2 <= 64'(ad_s1 * bn_s1);
		end
	end

	always_comb begin
		job = '0;
		job.err = err_s2;
		if (!err_s2) begin
			case (func_s2)
				3'(FUNC_ADD): begin
					job.num = p1_s2 + p2_s2;
					job.den = p3_s2;
				end
				3'(FUNC_SUB): begin
					job.num = p1_s2 - p2_s2;
					job.den = p3_s2;
				end
				3'(FUNC_MUL): begin
					job.num = p2_s2;
					job.den = p3_s2;
				end
				3'(FUNC_DIV): begin
					if (p4_s2 < 0) begin
						job.num = -p1_s2;
						job.den = -p4_s2;
					end else begin
						job.num = p1_s2;
						job.den = p4_s2;
					end
				end
				default: begin
					job.cmp = 1'b1;
					job.lt = p1_s2 < p2_s2;
					job.eq = p1_s2 == p2_s2;
					job.gt = p1_s2 > p2_s2;
				end
			endcase
		end
	end
	assign job_valid = v_s2;
endmodule

FILE: rtl/core/rau_queue.sv
// Small FIFO between front and back.
// Depends on rau_pkg.
module rau_queue #(
	parameter int unsigned DEPTH = rau_pkg::QueueDepth
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_valid,
	output logic          wr_ready,
	input  rau_pkg::job_t wr_data,
	output logic          rd_valid,
	input  logic          rd_ready,
	output rau_pkg::job_t rd_data
);
	import rau_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	job_t             mem_q [DEPTH];
	logic [AW-1:0]    wp_q, rp_q;
	logic [AW:0]      cnt_q;
	logic             wr, rd;

	assign wr_ready = cnt_q != (AW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	function automatic logic [AW-1:0] nxt(input logic [AW-1:0] p);
		nxt = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= nxt(wp_q);
			if (rd)
				rp_q <= nxt(rp_q);
			if (wr && !rd)
				cnt_q <= cnt_q + 1'b1;
			else if (rd && !wr)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem_q[wp_q] <= wr_data;
	end
endmodule

FILE: rtl/core/rau_back.sv
// Back part: binary gcd, two restoring divisions by the gcd, result register.
// Depends on rau_pkg.
module rau_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	output logic                job_ready,
	input  rau_pkg::job_t       job,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [63:0]  res_num,
	output logic [62:0]         res_den,
	output logic                status,
	output logic                is_less,
	output logic                is_equal,
	output logic                is_greater
);
	import rau_pkg::*;

	bk_state_t st_q, st_d;
	logic [63:0] x_q, y_q, g_q, mag_q, den_q, quo_q, rem_q, qn_q;
	logic [5:0]  sh_q;
	logic [6:0]  cnt_q;
	logic        neg_q;
	logic        load, gcd_done;

	logic [64:0] rtry;
	logic [63:0] src;
	assign src = (st_q == ST_DIVN) ? mag_q : den_q;
	assign rtry = {rem_q, src[6'd63 - cnt_q[5:0]]} - {1'b0, g_q};

	always_comb begin
		st_d = st_q;
		job_ready = 1'b0;
		load = 1'b0;
		gcd_done = (x_q == '0) || (y_q == '0) || (x_q == y_q);
		case (st_q)
			ST_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					load = 1'b1;
					st_d = (job.err || job.cmp) ? ST_OUT : ST_GCD;
				end
			end
			ST_GCD: if (gcd_done) st_d = ST_DIVN;
			ST_DIVN: if (cnt_q == 7'd63) st_d = ST_DIVD;
			ST_DIVD: if (cnt_q == 7'd63) st_d = ST_OUT;
			ST_OUT: if (out_ready) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
		end else begin
			st_q <= st_d;
		end
	end
	assign out_valid = st_q == ST_OUT;

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: if (load) begin
				status <= job.err;
				is_less <= job.lt;
				is_equal <= job.eq;
				is_greater <= job.gt;
				res_num <= '0;
				res_den <= '0;
				neg_q <= job.num < 0;
				mag_q <= job.num < 0 ? 64'(-job.num) : job.num;
				x_q <= job.num < 0 ? 64'(-job.num) : job.num;
				y_q <= job.den;
				den_q <= job.den;
				sh_q <= '0;
				cnt_q <= '0;
				rem_q <= '0;
			end
			ST_GCD: begin
				if (gcd_done) begin
					g_q <= ((x_q | y_q) == '0) ? 64'd1 :
						(((x_q == '0) ? y_q : x_q) << sh_q);
					cnt_q <= '0;
					rem_q <= '0;
				end else if (!x_q[0] && !y_q[0]) begin
					x_q <= x_q >> 1;
					y_q <= y_q >> 1;
					sh_q <= sh_q + 1'b1;
				end else if (!x_q[0]) begin
					x_q <= x_q >> 1;
				end else if (!y_q[0]) begin
					y_q <= y_q >> 1;
				end else if (x_q > y_q) begin
					x_q <= (x_q - y_q) >> 1;
				end else begin
					y_q <= (y_q - x_q) >> 1;
				end
			end
			ST_DIVN, ST_DIVD: begin
				quo_q <= {quo_q[62:0], !rtry[64]};
				if (cnt_q == 7'd63) begin
					cnt_q <= '0;
					rem_q <= '0;
					if (st_q == ST_DIVN)
						qn_q <= {quo_q[62:0], !rtry[64]};
					else begin
						res_num <= neg_q ? 64'(-qn_q) : qn_q;
						res_den <= quo_q[61:0] == '0 && rtry[64] ? 63'd0 :
							{quo_q[61:0], !rtry[64]};
					end
				end else begin
					cnt_q <= cnt_q + 1'b1;
					if (!rtry[64])
						rem_q <= rtry[63:0];
					else
						rem_q <= {rem_q[62:0], src[6'd63 - cnt_q[5:0]]};
				end
			end
			default: ;
		endcase
	end
endmodule

FILE: rtl/core/rational_arithmetic_unit.sv
// channel | dir | payload
// in      | sink   | func, first_num, first_den, second_num, second_den
// out     | source | res_num, res_den, status, is_less, is_equal, is_greater
// Front: two stages of cross products, one item per cycle into a two-entry queue while it has room.
// Back: binary gcd, two restoring divisions, then an output state held until the result is taken.
// Compare and error items skip the gcd and divisions.
// Reset is asynchronous; either side may stall independently.
// Depends on rau_pkg, rau_if, rau_front, rau_queue, rau_back.
module rational_arithmetic_unit #(
	parameter int unsigned OPERAND_WIDTH = rau_pkg::OperandWidth
) (
	input logic clk,
	input logic arst_n,
	rau_if.sink in,
	rau_if.source out
);
	import rau_pkg::*;

	logic f_valid, f_ready, q_valid, q_ready;
	job_t f_job, q_job;

	rau_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in.valid), .in_ready(in.ready),
		.in_func(in.data.func), .in_an(in.data.first_num), .in_ad(in.data.first_den),
		.in_bn(in.data.second_num), .in_bd(in.data.second_den),
		.job_valid(f_valid), .job_ready(f_ready), .job(f_job)
	);

	rau_queue #(.DEPTH(QueueDepth)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_job)
	);

	rau_back u_back (
		.clk(clk), .arst_n(arst_n),
		.job_valid(q_valid), .job_ready(q_ready), .job(q_job),
		.out_valid(out.valid), .out_ready(out.ready),
		.res_num(out.data.res_num), .res_den(out.data.res_den),
		.status(out.data.status), .is_less(out.data.is_less),
		.is_equal(out.data.is_equal), .is_greater(out.data.is_greater)
	);

`ifndef SYNTHESIS
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid |-> $countones({out.data.is_less, out.data.is_equal,
			out.data.is_greater}) <= 1)
		else $error("more than one compare flag");
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out.valid && out.data.status |-> out.data.res_den == '0)
		else $error("error item with denominator");
	a_q: assert property (@(posedge clk) disable iff (!arst_n)
		f_valid && !f_ready |=> f_valid)
		else $error("front dropped item");
`endif
endmodule

FILE: dv/rational_arithmetic_unit_tb.sv
// Testbench for rational_arithmetic_unit: directed and random fraction items,
// checked against an in-bench predictor of the reduced result and compare flags.
// Depends on rau_pkg, rau_if and rational_arithmetic_unit.
`timescale 1ns / 100ps

module rational_arithmetic_unit_tb;
	import rau_pkg::*;

	localparam int unsigned OPW = OperandWidth;
	localparam longint CYCLE_LIMIT = 4000000;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] first_num;
		logic signed [31:0] first_den;
		logic signed [31:0] second_num;
		logic signed [31:0] second_den;
	} op_item_t;

	typedef struct packed {
		logic signed [63:0] res_num;
		logic [62:0]        res_den;
		logic               status;
		logic               is_less;
		logic               is_equal;
		logic               is_greater;
	} frac_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rau_if #(.T(op_item_t)) op_ch (clk);
	rau_if #(.T(frac_item_t)) frac_ch (clk);

	rational_arithmetic_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in(op_ch),
		.out(frac_ch)
	);

	always #10 clk = ~clk;

	op_item_t   op_pending[$];
	frac_item_t frac_expected[$];
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	int         hold_request = 0;
	int         hold_left = 0;
	bit         op_taken = 1'b0;
	bit         failed = 1'b0;
	longint     cycles = 0;

	function automatic longint operand_value(logic [31:0] raw);
		longint v;
		longint maxv;
		maxv = (longint'(1) << (OPW - 1)) - 1;
		v = longint'(raw[OPW-1:0]);
		if (raw[OPW-1])
			v = v - (longint'(1) << OPW);
		if (v < -maxv)
			v = -maxv;
		return v;
	endfunction

	function automatic frac_item_t reduce_fraction(op_item_t op);
		frac_item_t r;
		longint an, ad, bn, bd, num, den, lhs, rhs;
		longint unsigned mag, d, g, a, b, t;
		bit neg;
		r = '0;
		an = operand_value(op.first_num);
		ad = operand_value(op.first_den);
		bn = operand_value(op.second_num);
		bd = operand_value(op.second_den);
		if (ad == 0 || bd == 0 || op.func > FUNC_CMP || (op.func == FUNC_DIV && bn == 0)) begin
			r.status = 1'b1;
			return r;
		end
		if (ad < 0) begin
			ad = -ad;
			an = -an;
		end
		if (bd < 0) begin
			bd = -bd;
			bn = -bn;
		end
		num = 0;
		den = 1;
		case (op.func)
			FUNC_ADD: begin
				num = an * bd + bn * ad;
				den = ad * bd;
			end
			FUNC_SUB: begin
				num = an * bd - bn * ad;
				den = ad * bd;
			end
			FUNC_MUL: begin
				num = an * bn;
				den = ad * bd;
			end
			FUNC_DIV: begin
				num = an * bd;
				den = ad * bn;
				if (den < 0) begin
					den = -den;
					num = -num;
				end
			end
			default: begin
				lhs = an * bd;
				rhs = bn * ad;
				r.is_less = lhs < rhs;
				r.is_equal = lhs == rhs;
				r.is_greater = lhs > rhs;
				return r;
			end
		endcase
		neg = num < 0;
		mag = neg ? -num : num;
		d = den;
		a = mag;
		b = d;
		while (b != 0) begin
			t = a % b;
			a = b;
			b = t;
		end
		g = (a == 0) ? 1 : a;
		mag = mag / g;
		d = d / g;
		r.res_num = neg ? -mag : mag;
		r.res_den = d[62:0];
		return r;
	endfunction

	function automatic logic [31:0] pick_field(bit is_den);
		case ($urandom_range(0, 9))
			0, 1, 2: return $urandom_range(0, 100) - 50;
			3: return is_den ? $urandom_range(1, 12) : $urandom_range(0, 24) - 12;
			4, 5, 6: return $urandom;
			7: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0001;
			8: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h0000_0000;
			default: return ($urandom_range(0, 2000) - 1000) * ($urandom_range(1, 3) * 6);
		endcase
	endfunction

	task automatic queue_op(logic [2:0] f, logic [31:0] an, logic [31:0] ad,
	                        logic [31:0] bn, logic [31:0] bd);
		op_item_t op;
		op.func = f;
		op.first_num = an;
		op.first_den = ad;
		op.second_num = bn;
		op.second_den = bd;
		op_pending.push_back(op);
	endtask

	task automatic queue_random(int n);
		logic [2:0] f;
		for (int i = 0; i < n; i++) begin
			f = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
			queue_op(f, pick_field(0), pick_field(1), pick_field(0), pick_field(1));
		end
	endtask

	task automatic drain();
		wait (op_pending.size() == 0 && !op_ch.valid && frac_expected.size() == 0);
		@(posedge clk);
	endtask

	// input side: posedge records acceptance and the expected result
	always @(posedge clk) begin
		op_taken = op_ch.valid && op_ch.ready;
		if (op_taken)
			frac_expected.push_back(reduce_fraction(op_ch.data));
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout", $time);
			$display("rational_arithmetic_unit verification failed");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			op_ch.valid <= 1'b0;
			op_ch.data <= '0;
		end else if (!op_ch.valid || op_taken) begin
			if (op_pending.size() > 0 && $urandom_range(1, 100) > send_idle_pct)
				begin
				op_ch.data <= op_pending.pop_front();
				op_ch.valid <= 1'b1;
			end else begin
				op_ch.valid <= 1'b0;
			end
		end
		op_taken = 1'b0;
	end

	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (!arst_n) begin
			frac_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			frac_ch.ready <= 1'b0;
		end else begin
			frac_ch.ready <= $urandom_range(1, 100) > recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		frac_item_t got, want;
		if (frac_ch.valid && frac_ch.ready) begin
			got = frac_ch.data;
			if (frac_expected.size() == 0) begin
				$display("%0t unexpected result: actual %p", $time, got);
				failed = 1'b1;
			end else begin
				want = frac_expected.pop_front();
				if (got.res_num !== want.res_num) begin
					$display("%0t res_num: expected %0d actual %0d", $time, want.res_num, got.res_num);
					failed = 1'b1;
				end
				if (got.res_den !== want.res_den) begin
					$display("%0t res_den: expected %0d actual %0d", $time, want.res_den, got.res_den);
					failed = 1'b1;
				end
				if (got.status !== want.status) begin
					$display("%0t status: expected %0b actual %0b", $time, want.status, got.status);
					failed = 1'b1;
				end
				if (got.is_less !== want.is_less) begin
					$display("%0t is_less: expected %0b actual %0b", $time, want.is_less, got.is_less);
					failed = 1'b1;
				end
				if (got.is_equal !== want.is_equal) begin
					$display("%0t is_equal: expected %0b actual %0b", $time, want.is_equal,
					         got.is_equal);
					failed = 1'b1;
				end
				if (got.is_greater !== want.is_greater) begin
					$display("%0t is_greater: expected %0b actual %0b", $time, want.is_greater,
					         got.is_greater);
					failed = 1'b1;
				end
			end
		end
	end

	initial begin
		op_ch.valid = 1'b0;
		op_ch.data = '0;
		frac_ch.ready = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, every operation, error and sign cases
		queue_op(FUNC_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
		queue_op(FUNC_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
		queue_op(FUNC_MUL, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'd1);
		queue_op(FUNC_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd1);
		queue_op(FUNC_DIV, 32'd3, 32'd4, 32'hffff_fffe, 32'd5);
		queue_op(FUNC_DIV, 32'd3, 32'd4, 32'd0, 32'd5);
		queue_op(FUNC_CMP, 32'd1, 32'd2, 32'hffff_fffe, 32'hffff_fffc);
		queue_op(FUNC_CMP, 32'd1, 32'hffff_ffff, 32'd0, 32'd1);
		queue_op(FUNC_CMP, 32'h7fff_ffff, 32'd1, 32'h8000_0000, 32'd1);
		queue_op(FUNC_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
		queue_op(FUNC_CMP, 32'd1, 32'd1, 32'd1, 32'd0);
		queue_op(3'd5, 32'd1, 32'd1, 32'd1, 32'd1);
		queue_op(3'd7, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
		queue_op(FUNC_ADD, 32'd0, 32'd7, 32'd0, 32'hffff_fff9);
		queue_op(FUNC_SUB, 32'h8000_0001, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0001);
		queue_op(FUNC_ADD, 32'h7fff_ffff, 32'h7fff_fffe, 32'h7fff_ffff, 32'h7fff_fffd);
		queue_op(FUNC_MUL, 32'd6, 32'hffff_fff7, 32'hffff_fff4, 32'd10);
		queue_op(FUNC_DIV, 32'hffff_fffd, 32'hffff_fff9, 32'h8000_0000, 32'h7fff_ffff);
		queue_op(FUNC_CMP, 32'h5555_5555, 32'haaaa_aaab, 32'h0, 32'h8000_0000);
		drain();

		queue_random(350);
		drain();
		send_idle_pct = 74;
		queue_random(350);
		drain();
		send_idle_pct = 0;
		recv_stall_pct = 74;
		queue_random(350);
		drain();
		send_idle_pct = 32;
		recv_stall_pct = 32;
		queue_random(350);
		drain();

		// long receiver hold-off while the sender keeps offering items
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 3000;
		queue_random(100);
		drain();

		repeat (500) @(posedge clk);
		if (!failed && frac_expected.size() == 0)
			$display("rational_arithmetic_unit verification clean");
		else
			$display("rational_arithmetic_unit verification failed");
		$finish;
	end

endmodule
